// File: design/sfcrc_pkg.sv
// ----------------------------------------------------------------------------
// sfcrc_pkg
// Shared types, constants and the byte-wide CRC-16 update for the sensor
// response frame checker.
// ----------------------------------------------------------------------------
package sfcrc_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] word_t;
  typedef logic [2:0]  pos_t;

  localparam int unsigned FRAME_BYTES = 8;

  localparam word_t CRC_INIT = 16'hFFFF;
  localparam word_t CRC_POLY = 16'hA001;

  // byte positions inside a response frame
  localparam pos_t POS_FUNC   = 3'd0;
  localparam pos_t POS_HUM_HI = 3'd2;
  localparam pos_t POS_HUM_LO = 3'd3;
  localparam pos_t POS_TMP_HI = 3'd4;
  localparam pos_t POS_TMP_LO = 3'd5;
  localparam pos_t POS_CRC_LO = 3'd6;
  localparam pos_t POS_CRC_HI = pos_t'(FRAME_BYTES - 1);

  // reflected CRC-16, LSB first, one byte
  function automatic word_t crc16_byte(input word_t crc, input byte_t b);
    word_t c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: design/sfcrc_if.sv
// ----------------------------------------------------------------------------
// sfcrc_if
// Valid/ready channels of the sensor response frame checker: the byte input
// channel and the frame result channel.
// ----------------------------------------------------------------------------
interface sfcrc_in_if;
  import sfcrc_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rx_byte;
  logic  frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface sfcrc_out_if;
  import sfcrc_pkg::*;

  logic  valid;
  logic  ready;
  word_t humidity_raw;
  word_t temperature_raw;
  logic  crc_ok;
  logic  data_available;

  modport source (output valid, output humidity_raw, output temperature_raw,
                  output crc_ok, output data_available, input ready);
  modport sink   (input valid, input humidity_raw, input temperature_raw,
                  input crc_ok, input data_available, output ready);
endinterface

// File: design/sensor_frame_crc_checker_unit.sv
// ----------------------------------------------------------------------------
// sensor_frame_crc_checker_unit
// Checks 8-byte sensor response frames with a reflected CRC-16 and latches
// the humidity and temperature words of good frames.
// ----------------------------------------------------------------------------
// An eighth byte passes the input register, then its result word is registered for out_ch.
// Throughput: one byte per cycle while no byte stalls; the byte-wide CRC update between the input
//   register and the frame state sets the path, one byte per clock.
// Only a byte that ends a frame stalls in the input register, and only while a result word is held and not taken.
// Reset (rst_n low, synchronous): frame position to zero, CRC to 0xFFFF,
//   latched words to zero, both channel registers empty.
// ----------------------------------------------------------------------------
module sensor_frame_crc_checker_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  sfcrc_in_if.sink             in_ch,
  sfcrc_out_if.source          out_ch
);
  import sfcrc_pkg::*;

  // input register
  logic  in_valid_r;
  byte_t in_byte_r;
  logic  in_start_r;

  // frame state
  pos_t  pos_r,      pos_nxt;
  word_t crc_r,      crc_nxt;
  word_t hum_pend_r, hum_pend_nxt;
  word_t tmp_pend_r, tmp_pend_nxt;
  byte_t crc_lo_r,   crc_lo_nxt;
  word_t hum_str_r,  hum_str_nxt;
  word_t tmp_str_r,  tmp_str_nxt;

  // result register
  logic  out_valid_r;
  word_t out_hum_r;
  word_t out_tmp_r;
  logic  out_ok_r;
  logic  out_avail_r;

  pos_t  pos_eff;
  word_t crc_base;
  word_t crc_upd;
  word_t rx_crc;
  logic  crc_match;
  logic  emit;
  logic  out_free;
  logic  proc_adv;

  assign pos_eff  = in_start_r ? POS_FUNC : pos_r;
  assign crc_base = in_start_r ? CRC_INIT : crc_r;
  assign crc_upd  = crc16_byte(crc_base, in_byte_r);
  assign rx_crc   = {in_byte_r, crc_lo_r};
  assign crc_match = (rx_crc == crc_base);
  assign emit     = (pos_eff == POS_CRC_HI);

  assign out_free = !out_valid_r || out_ch.ready;
  // a byte that ends a frame waits for room in the result register
  assign proc_adv = in_valid_r && (!emit || out_free);

  assign in_ch.ready = !in_valid_r || proc_adv;

  always_comb begin
    pos_nxt      = pos_r;
    crc_nxt      = crc_r;
    hum_pend_nxt = hum_pend_r;
    tmp_pend_nxt = tmp_pend_r;
    crc_lo_nxt   = crc_lo_r;
    hum_str_nxt  = hum_str_r;
    tmp_str_nxt  = tmp_str_r;
    if (proc_adv) begin
      pos_nxt = pos_eff + pos_t'(1);
      crc_nxt = (pos_eff < POS_CRC_LO) ? crc_upd : crc_base;
      case (pos_eff)
        POS_HUM_HI: hum_pend_nxt = {in_byte_r, hum_pend_r[7:0]};
        POS_HUM_LO: hum_pend_nxt = {hum_pend_r[15:8], in_byte_r};
        POS_TMP_HI: tmp_pend_nxt = {in_byte_r, tmp_pend_r[7:0]};
        POS_TMP_LO: tmp_pend_nxt = {tmp_pend_r[15:8], in_byte_r};
        POS_CRC_LO: crc_lo_nxt   = in_byte_r;
        POS_CRC_HI: begin
          if (crc_match) begin
            hum_str_nxt = hum_pend_r;
            tmp_str_nxt = tmp_pend_r;
          end
          pos_nxt = POS_FUNC;
          crc_nxt = CRC_INIT;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      pos_r       <= POS_FUNC;
      crc_r       <= CRC_INIT;
      hum_pend_r  <= '0;
      tmp_pend_r  <= '0;
      crc_lo_r    <= '0;
      hum_str_r   <= '0;
      tmp_str_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      pos_r      <= pos_nxt;
      crc_r      <= crc_nxt;
      hum_pend_r <= hum_pend_nxt;
      tmp_pend_r <= tmp_pend_nxt;
      crc_lo_r   <= crc_lo_nxt;
      hum_str_r  <= hum_str_nxt;
      tmp_str_r  <= tmp_str_nxt;
      if (proc_adv && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.ready) begin
      in_byte_r  <= in_ch.rx_byte;
      in_start_r <= in_ch.frame_start;
    end
    if (proc_adv && emit) begin
      out_hum_r   <= hum_str_nxt;
      out_tmp_r   <= tmp_str_nxt;
      out_ok_r    <= crc_match;
      out_avail_r <= (hum_str_nxt != '0) || (tmp_str_nxt != '0);
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.humidity_raw    = out_hum_r;
  assign out_ch.temperature_raw = out_tmp_r;
  assign out_ch.crc_ok          = out_ok_r;
  assign out_ch.data_available  = out_avail_r;

  // a finished frame restarts the position and the CRC
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_adv && emit) |=> (pos_r == POS_FUNC) && (crc_r == CRC_INIT))
    else $error("frame state not restarted after result");

  // a failed check leaves the latched words alone
  a_fail_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_adv && emit && !crc_match) |=> $stable(hum_str_r) && $stable(tmp_str_r))
    else $error("latched words changed on failed check");

  // latched words move only on the last byte of a frame
  a_latch_only_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    !(proc_adv && emit) |=> $stable(hum_str_r) && $stable(tmp_str_r))
    else $error("latched words changed outside frame end");

  // a held byte stays in the input register
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !proc_adv) |=> in_valid_r && $stable(in_byte_r) && $stable(in_start_r))
    else $error("input register lost a stalled byte");

  // availability flag agrees with the reported words
  a_avail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_avail_r == ((out_hum_r != '0) || (out_tmp_r != '0))))
    else $error("data_available does not match reported words");

endmodule
